### src/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement package
// Shared constants, the back-end state type and the queue status bundle.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int FRAME_SLOTS_DEFAULT = 16;
    localparam int PAGE_BITS_DEFAULT   = 10;

    localparam int               CFG_W             = 5;
    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 5'd4;

    localparam int FAULT_W       = 16;
    localparam int FRAME_IDX_W   = 4;
    localparam int FRAMES_USED_W = 5;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_EVICT
    } cpr_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cpr_q_status_t;

endpackage

### src/clock_page_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement core
// Second-chance page replacement over a configurable set of frames.
// ----------------------------------------------------------------------------
// A reference is taken when start is high and busy is low; its result shows
// for exactly one cycle with done high and must be captured then, as the core
// cannot be held off. A lookup searches the filled frames below the frame
// count, one frame table read per cycle; on a replacement fault (N = active
// frames) the clock hand then visits at most N + 1 frames, one per cycle.
// References are queued two deep in front of the back end, so busy rises
// only when that queue is full.
// Write the frame count on the cfg channel only while the core is idle.
// ----------------------------------------------------------------------------
module clock_page_replacement_core #(
    parameter int MAX_FRAME_SLOTS = cpr_pkg::FRAME_SLOTS_DEFAULT,
    parameter int PAGE_BITS       = cpr_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // reference channel
    input  logic                              start,
    output logic                              busy,
    input  logic [PAGE_BITS-1:0]              page,
    // result channel
    output logic                              done,
    output logic                              hit,
    output logic [cpr_pkg::FRAME_IDX_W-1:0]   frame_index,
    output logic                              evicted,
    output logic [PAGE_BITS-1:0]              evicted_page,
    output logic [cpr_pkg::FAULT_W-1:0]       fault_total,
    output logic [cpr_pkg::FRAMES_USED_W-1:0] frames_used,
    // frame count register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpr_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CNT_W   = $clog2(MAX_FRAME_SLOTS + 1);
    localparam int ENTRY_W = PAGE_BITS + CNT_W;

    cpr_pkg::cpr_q_status_t q_status;
    logic                   q_push;
    logic                   q_pop;
    logic [ENTRY_W-1:0]     q_wr_data;
    logic [ENTRY_W-1:0]     q_rd_data;

    // Front end: accept each transfer, clamp the frame count and queue both.
    cpr_front #(
        .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS),
        .PAGE_BITS       (PAGE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .page      (page),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    // Decouple the two halves so each can stall on its own.
    cpr_queue #(
        .DEPTH (cpr_pkg::QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // Back end: search, load or sweep the hand, then strobe the result.
    cpr_back #(
        .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS),
        .PAGE_BITS       (PAGE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_rd_data),
        .q_pop        (q_pop),
        .done         (done),
        .hit          (hit),
        .frame_index  (frame_index),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .fault_total  (fault_total),
        .frames_used  (frames_used)
    );

endmodule

### src/cpr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement request queue
// Short FIFO that decouples the accepting front end from the back end.
// ----------------------------------------------------------------------------
module cpr_queue #(
    parameter int DEPTH = cpr_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rd_data,
    output cpr_pkg::cpr_q_status_t status
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        if (32'(ptr) == DEPTH - 1)
            return '0;
        else
            return ptr + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign status.full  = (32'(count_reg) == DEPTH);
    assign status.empty = (count_reg == '0);

endmodule

### src/cpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement front end
// Holds the frame count register, clamps it and queues each reference.
// ----------------------------------------------------------------------------
module cpr_front #(
    parameter int MAX_FRAME_SLOTS = cpr_pkg::FRAME_SLOTS_DEFAULT,
    parameter int PAGE_BITS       = cpr_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [PAGE_BITS-1:0]                  page,
    output logic                                  busy,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cpr_pkg::CFG_W-1:0]             cfg_data,
    input  cpr_pkg::cpr_q_status_t                q_status,
    output logic                                  q_push,
    output logic [PAGE_BITS+$clog2(MAX_FRAME_SLOTS+1)-1:0] q_data
);

    localparam int CNT_W = $clog2(MAX_FRAME_SLOTS + 1);

    logic [cpr_pkg::CFG_W-1:0] frame_count_reg;
    logic [CNT_W-1:0]          active_frames;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_count_reg <= cpr_pkg::FRAME_COUNT_RESET;
        else if (cfg_valid && cfg_ready)
            frame_count_reg <= cfg_data;
    end

    // Clamp to 1..MAX_FRAME_SLOTS.
    always_comb
    begin
        if (frame_count_reg == '0)
            active_frames = CNT_W'(1);
        else if (32'(frame_count_reg) > MAX_FRAME_SLOTS)
            active_frames = CNT_W'(MAX_FRAME_SLOTS);
        else
            active_frames = CNT_W'(frame_count_reg);
    end

    assign cfg_ready = 1'b1;
    assign busy      = q_status.full;
    assign q_push    = start && !q_status.full;
    assign q_data    = {page, active_frames};

endmodule

### src/cpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement back end
// Scans the frame table, loads or sweeps the clock hand and drives results.
// ----------------------------------------------------------------------------
module cpr_back #(
    parameter int MAX_FRAME_SLOTS = cpr_pkg::FRAME_SLOTS_DEFAULT,
    parameter int PAGE_BITS       = cpr_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cpr_pkg::cpr_q_status_t                q_status,
    input  logic [PAGE_BITS+$clog2(MAX_FRAME_SLOTS+1)-1:0] q_data,
    output logic                                  q_pop,
    output logic                                  done,
    output logic                                  hit,
    output logic [cpr_pkg::FRAME_IDX_W-1:0]       frame_index,
    output logic                                  evicted,
    output logic [PAGE_BITS-1:0]                  evicted_page,
    output logic [cpr_pkg::FAULT_W-1:0]           fault_total,
    output logic [cpr_pkg::FRAMES_USED_W-1:0]     frames_used
);

    localparam int SLOT_W = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAME_SLOTS + 1);
    localparam int IDX_W  = cpr_pkg::FRAME_IDX_W;
    localparam int USED_W = cpr_pkg::FRAMES_USED_W;
    localparam int FLT_W  = cpr_pkg::FAULT_W;

    cpr_pkg::cpr_state_t state_reg, state_next;

    logic [PAGE_BITS-1:0]       page_reg, page_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           search_reg, search_next;
    logic [CNT_W-1:0]           scan_reg, scan_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]          hand_reg, hand_next;
    logic [SLOT_W-1:0]          victim_reg, victim_next;
    logic [CNT_W-1:0]           occ_reg, occ_next;
    logic [FLT_W-1:0]           fault_reg, fault_next;
    logic [MAX_FRAME_SLOTS-1:0] use_bits_reg, use_bits_next;
    logic                       done_reg, done_next;

    logic                       res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]           res_frame_reg, res_frame_next;
    logic                       res_evicted_reg, res_evicted_next;
    logic [PAGE_BITS-1:0]       res_evpage_reg, res_evpage_next;

    logic [PAGE_BITS-1:0]       page_mem [MAX_FRAME_SLOTS];
    logic [PAGE_BITS-1:0]       rd_data_reg;
    logic                       mem_we;
    logic [SLOT_W-1:0]          mem_waddr;
    logic [SLOT_W-1:0]          mem_raddr;

    logic [PAGE_BITS-1:0]       entry_page;
    logic [CNT_W-1:0]           entry_n;
    logic                       match;
    logic                       last_cmp;
    logic                       has_free;
    logic [SLOT_W-1:0]          hand_inc;
    logic                       victim_found;

    assign entry_page = q_data[PAGE_BITS+CNT_W-1:CNT_W];
    assign entry_n    = q_data[CNT_W-1:0];

    assign match    = cmp_valid_reg && (rd_data_reg == page_reg);
    assign last_cmp = (search_reg == '0) ||
                      (cmp_valid_reg && (CNT_W'(cmp_idx_reg) == search_reg - 1'b1));
    assign has_free = (occ_reg < n_reg);
    assign hand_inc = (CNT_W'(hand_reg) + 1'b1 == n_reg) ? '0 : hand_reg + 1'b1;
    assign victim_found = !use_bits_reg[hand_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpr_pkg::ST_IDLE:
                if (!q_status.empty)
                    state_next = cpr_pkg::ST_LOOKUP;
            cpr_pkg::ST_LOOKUP:
                if (match || (last_cmp && has_free))
                    state_next = cpr_pkg::ST_IDLE;
                else if (last_cmp)
                    state_next = cpr_pkg::ST_SWEEP;
            cpr_pkg::ST_SWEEP:
                if (victim_found)
                    state_next = cpr_pkg::ST_EVICT;
            cpr_pkg::ST_EVICT:
                state_next = cpr_pkg::ST_IDLE;
            default:
                state_next = cpr_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_pop            = 1'b0;
        page_next        = page_reg;
        n_next           = n_reg;
        search_next      = search_reg;
        scan_next        = scan_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        hand_next        = hand_reg;
        victim_next      = victim_reg;
        occ_next         = occ_reg;
        fault_next       = fault_reg;
        use_bits_next    = use_bits_reg;
        done_next        = 1'b0;
        res_hit_next     = res_hit_reg;
        res_frame_next   = res_frame_reg;
        res_evicted_next = res_evicted_reg;
        res_evpage_next  = res_evpage_reg;
        mem_we           = 1'b0;
        mem_waddr        = victim_reg;
        mem_raddr        = scan_reg[SLOT_W-1:0];

        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop       = 1'b1;
                    page_next   = entry_page;
                    n_next      = entry_n;
                    search_next = (occ_reg < entry_n) ? occ_reg : entry_n;
                    scan_next   = '0;
                end
            end
            cpr_pkg::ST_LOOKUP:
            begin
                // Issue one read per cycle, compare the one issued before.
                if (scan_reg < search_reg)
                begin
                    scan_next      = scan_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[SLOT_W-1:0];
                end
                if (match)
                begin
                    use_bits_next[cmp_idx_reg] = 1'b1;
                    done_next        = 1'b1;
                    res_hit_next     = 1'b1;
                    res_frame_next   = IDX_W'(cmp_idx_reg);
                    res_evicted_next = 1'b0;
                    res_evpage_next  = '0;
                end
                else if (last_cmp && has_free)
                begin
                    // Cold load into the next free frame.
                    mem_we           = 1'b1;
                    mem_waddr        = occ_reg[SLOT_W-1:0];
                    use_bits_next[occ_reg[SLOT_W-1:0]] = 1'b1;
                    occ_next         = occ_reg + 1'b1;
                    done_next        = 1'b1;
                    res_hit_next     = 1'b0;
                    res_frame_next   = IDX_W'(occ_reg[SLOT_W-1:0]);
                    res_evicted_next = 1'b0;
                    res_evpage_next  = '0;
                end
                else if (last_cmp)
                begin
                    if (fault_reg != '1)
                        fault_next = fault_reg + 1'b1;
                    if (CNT_W'(hand_reg) >= n_reg)
                        hand_next = '0;
                end
            end
            cpr_pkg::ST_SWEEP:
            begin
                mem_raddr = hand_reg;
                hand_next = hand_inc;
                if (victim_found)
                begin
                    victim_next             = hand_reg;
                    use_bits_next[hand_reg] = 1'b1;
                end
                else
                begin
                    use_bits_next[hand_reg] = 1'b0;
                end
            end
            cpr_pkg::ST_EVICT:
            begin
                mem_we           = 1'b1;
                mem_waddr        = victim_reg;
                done_next        = 1'b1;
                res_hit_next     = 1'b0;
                res_frame_next   = IDX_W'(victim_reg);
                res_evicted_next = 1'b1;
                res_evpage_next  = rd_data_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::ST_IDLE;
            cmp_valid_reg <= 1'b0;
            hand_reg      <= '0;
            occ_reg       <= '0;
            fault_reg     <= '0;
            use_bits_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            hand_reg      <= hand_next;
            occ_reg       <= occ_next;
            fault_reg     <= fault_next;
            use_bits_reg  <= use_bits_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg        <= page_next;
        n_reg           <= n_next;
        search_reg      <= search_next;
        scan_reg        <= scan_next;
        cmp_idx_reg     <= cmp_idx_next;
        victim_reg      <= victim_next;
        res_hit_reg     <= res_hit_next;
        res_frame_reg   <= res_frame_next;
        res_evicted_reg <= res_evicted_next;
        res_evpage_reg  <= res_evpage_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            page_mem[mem_waddr] <= page_reg;
        rd_data_reg <= page_mem[mem_raddr];
    end

    assign done         = done_reg;
    assign hit          = res_hit_reg;
    assign frame_index  = res_frame_reg;
    assign evicted      = res_evicted_reg;
    assign evicted_page = res_evpage_reg;
    assign fault_total  = fault_reg;
    assign frames_used  = USED_W'(occ_reg);

endmodule

### src/cpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement checker
// Port-level properties of the core's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cpr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              done,
    input logic                              hit,
    input logic                              evicted,
    input logic [cpr_pkg::FAULT_W-1:0]       fault_total,
    input logic [cpr_pkg::FRAMES_USED_W-1:0] frames_used
);

    // Results never come in back-to-back cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done strobed in consecutive cycles");

    // A hit never replaces a page.
    assert property (@(posedge clk) disable iff (!rst_n) (done && evicted) |-> !hit)
        else $error("eviction reported on a hit");

    // Fault count never drops.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (fault_total >= $past(fault_total)))
        else $error("fault count decreased");

    // Hits and replacements leave occupancy unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (hit || evicted)) |-> $stable(frames_used))
        else $error("occupancy changed on hit or replacement");

    // Hits and cold loads count no fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> $stable(fault_total))
        else $error("fault counted without eviction");

endmodule

bind clock_page_replacement_core cpr_checker u_cpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .hit         (hit),
    .evicted     (evicted),
    .fault_total (fault_total),
    .frames_used (frames_used)
);

### dv/tb_clock_page_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock page replacement core testbench
// Sends page references through the start/busy port and predicts every
// result with a second-chance model kept inside the bench. Each done strobe
// is compared field by field with the oldest prediction. Coverage comes from
// directed cold-fill, hit and frame count cases, then randomized
// working-set traffic over many frame count settings.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement_core;

    localparam int SLOTS         = cpr_pkg::FRAME_SLOTS_DEFAULT;
    localparam int PB            = cpr_pkg::PAGE_BITS_DEFAULT;
    localparam int PAGE_MAX      = (1 << PB) - 1;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    // Cycle limit for the watchdog, set well above the slowest legal run.
    localparam int CYCLE_LIMIT   = 3_000_000;
    // Worst case back-end time for one reference (full sweep over all slots).
    localparam int SETTLE_CYCLES = 2 * SLOTS + 4;
    localparam int PHASE_ITEMS   = 132;
    localparam int HOT_DEPTH     = 24;

    localparam logic [cpr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

    typedef struct packed {
        logic                              hit;
        logic [cpr_pkg::FRAME_IDX_W-1:0]   frame_index;
        logic                              evicted;
        logic [PB-1:0]                     evicted_page;
        logic [cpr_pkg::FAULT_W-1:0]       fault_total;
        logic [cpr_pkg::FRAMES_USED_W-1:0] frames_used;
    } page_outcome_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              start     = 1'b0;
    logic [PB-1:0]                     page      = '0;
    logic                              cfg_valid = 1'b0;
    logic [cpr_pkg::CFG_W-1:0]         cfg_data  = '0;
    logic                              busy;
    logic                              done;
    logic                              hit;
    logic [cpr_pkg::FRAME_IDX_W-1:0]   frame_index;
    logic                              evicted;
    logic [PB-1:0]                     evicted_page;
    logic [cpr_pkg::FAULT_W-1:0]       fault_total;
    logic [cpr_pkg::FRAMES_USED_W-1:0] frames_used;
    logic                              cfg_ready;

    clock_page_replacement_core #(
        .MAX_FRAME_SLOTS (SLOTS),
        .PAGE_BITS       (PB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .page         (page),
        .done         (done),
        .hit          (hit),
        .frame_index  (frame_index),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .fault_total  (fault_total),
        .frames_used  (frames_used),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the frame table and the clock hand
    // ------------------------------------------------------------------------
    logic [cpr_pkg::CFG_W-1:0]   frames_cfg            = cpr_pkg::FRAME_COUNT_RESET;
    logic [PB-1:0]               resident_page [SLOTS] = '{default: '0};
    logic                        second_chance [SLOTS] = '{default: 1'b0};
    int                          hand_pos              = 0;
    int                          loaded_frames         = 0;
    logic [cpr_pkg::FAULT_W-1:0] fault_tally           = '0;

    page_outcome_t pending_outcomes [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;

    // Frame count as the policy sees it: zero acts as one, large values clip.
    function automatic int active_frames();
        if (frames_cfg == '0)
            return 1;
        if (frames_cfg > SLOTS)
            return SLOTS;
        return int'(frames_cfg);
    endfunction

    // Apply one reference to the predictor and return the result it implies.
    function automatic page_outcome_t predict_outcome(input logic [PB-1:0] p);
        page_outcome_t o;
        int            n;
        int            search;
        int            j;
        int            steps;
        bit            found;
        o      = '0;
        found  = 1'b0;
        n      = active_frames();
        // Look only below the smaller of the fill level and the frame count,
        // which matters once the count has been lowered under a full table.
        search = (loaded_frames < n) ? loaded_frames : n;
        for (j = 0; j < search && !found; j++)
        begin
            if (resident_page[j] == p)
            begin
                found            = 1'b1;
                o.hit            = 1'b1;
                o.frame_index    = cpr_pkg::FRAME_IDX_W'(j);
                second_chance[j] = 1'b1;
            end
        end
        if (!found)
        begin
            if (loaded_frames < n)
            begin
                // Cold load into the next free frame; not a fault.
                o.frame_index                = cpr_pkg::FRAME_IDX_W'(loaded_frames);
                resident_page[loaded_frames] = p;
                second_chance[loaded_frames] = 1'b1;
                loaded_frames++;
            end
            else
            begin
                if (fault_tally != FAULT_MAX)
                    fault_tally++;
                // Restart the hand if the frame count shrank beneath it.
                if (hand_pos >= n)
                    hand_pos = 0;
                for (steps = 0; steps < 2 * SLOTS + 2 && !o.evicted; steps++)
                begin
                    if (!second_chance[hand_pos])
                    begin
                        o.frame_index           = cpr_pkg::FRAME_IDX_W'(hand_pos);
                        o.evicted_page          = resident_page[hand_pos];
                        o.evicted               = 1'b1;
                        resident_page[hand_pos] = p;
                        second_chance[hand_pos] = 1'b1;
                    end
                    else
                    begin
                        second_chance[hand_pos] = 1'b0;
                    end
                    hand_pos = (hand_pos + 1) % n;
                end
            end
        end
        o.fault_total = fault_tally;
        o.frames_used = cpr_pkg::FRAMES_USED_W'(loaded_frames);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Present one page and hold start until the transfer completes. Start is
    // left high so that the next reference can follow on the very next cycle.
    task automatic send_reference(input logic [PB-1:0] p);
        start <= 1'b1;
        page  <= p;
        do
            @(posedge clk);
        while (busy);
        pending_outcomes.push_back(predict_outcome(p));
    endtask

    // Drop start for a number of cycles between bursts.
    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every predicted result has been seen.
    task automatic drain_outcomes();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    // One transfer on the frame count write channel; call only when drained.
    task automatic write_frame_count(input logic [cpr_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        frames_cfg  = value;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every done strobe must match the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string field_name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field_name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        page_outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("done with no reference outstanding: frame_index %0d",
                       frame_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("hit",          32'(want.hit),          32'(hit));
                check_field("frame_index",  32'(want.frame_index),  32'(frame_index));
                check_field("evicted",      32'(want.evicted),      32'(evicted));
                check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
                check_field("fault_total",  32'(want.fault_total),  32'(fault_total));
                check_field("frames_used",  32'(want.frames_used),  32'(frames_used));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset frame count of four: fill the table cold, hit, then force sweeps
    // that must clear every bit and evict, with page extremes among them.
    task automatic test_cold_fill_and_hits();
        logic [PB-1:0] refs [12];
        int            k;
        refs = '{10'd0, 10'd1023, 10'd0, 10'd682, 10'd341, 10'd1023,
                 10'd85, 10'd0, 10'd85, 10'd512, 10'd1023, 10'd3};
        for (k = 0; k < 12; k++)
            send_reference(refs[k]);
    endtask

    // Frame count extremes: clipped maximum, zero acting as one while the
    // table holds more pages, and the plain limits on either side.
    task automatic test_frame_count_extremes();
        drain_outcomes();
        write_frame_count(5'd31);
        send_reference(10'd1);
        send_reference(10'd2);
        send_reference(10'd1023);
        drain_outcomes();
        write_frame_count(5'd0);
        send_reference(10'd600);
        send_reference(10'd601);
        send_reference(10'd600);
        drain_outcomes();
        write_frame_count(5'd16);
        send_reference(10'd341);
        send_reference(10'd602);
        drain_outcomes();
        write_frame_count(5'd1);
        send_reference(10'd1023);
    endtask

    // One setting of the frame count with working-set traffic: mostly pages
    // from a hot set of the frame count plus zero to four pages, so that hits,
    // sweeps and evictions mix, plus uniform noise and the page extremes.
    task automatic run_reference_phase(input logic [cpr_pkg::CFG_W-1:0] count);
        logic [PB-1:0] hot_pages [HOT_DEPTH];
        logic [PB-1:0] p;
        int            hot_size;
        int            k;
        int            burst_left;
        int            choice;
        drain_outcomes();
        write_frame_count(count);
        frames_cfg = count;
        hot_size   = active_frames() + $urandom_range(0, 4);
        for (k = 0; k < hot_size; k++)
            hot_pages[k] = PB'($urandom_range(0, PAGE_MAX));
        burst_left = 0;
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                // Let about a third of the bursts run on without a gap.
                if ($urandom_range(0, 2) != 0)
                    sender_gap($urandom_range(1, 40));
            end
            burst_left--;
            choice = $urandom_range(0, 99);
            if (choice < 80)
                p = hot_pages[$urandom_range(0, hot_size - 1)];
            else if (choice < 92)
                p = PB'($urandom_range(0, PAGE_MAX));
            else if (choice < 96)
                p = '0;
            else
                p = '1;
            send_reference(p);
        end
    endtask

    // Walk through many settings, raising and lowering the count so that the
    // hand and the fill level end up beyond it.
    task automatic test_random_references();
        logic [cpr_pkg::CFG_W-1:0] counts [14];
        int                        k;
        counts = '{5'd2, 5'd1, 5'd0, 5'd7, 5'd16, 5'd31, 5'd3, 5'd12,
                   5'd17, 5'd5, 5'd9, 5'd16, 5'd0, 5'd0};
        counts[12] = cpr_pkg::CFG_W'($urandom_range(0, 31));
        counts[13] = cpr_pkg::CFG_W'($urandom_range(0, 31));
        for (k = 0; k < 14; k++)
            run_reference_phase(counts[k]);
    endtask

    // ------------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_cold_fill_and_hits();
        test_frame_count_extremes();
        test_random_references();
        drain_outcomes();
        // Leave room for any stray done after the last expected one.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: stop a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
src/cpr_pkg.sv
src/cpr_queue.sv
src/cpr_front.sv
src/cpr_back.sv
src/clock_page_replacement_core.sv
src/cpr_checker.sv
dv/tb_clock_page_replacement_core.sv
